// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks on clk with asynchronous reset arst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C2D_ASSERT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define C2D_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: sv/c2d_pkg.sv
// ---------------------------------------------------------------------------
// c2d_pkg
// Constants, register indexes and shared types of the 3x3 convolution block.
// ---------------------------------------------------------------------------
package c2d_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int LB_AW       = $clog2(MAX_WIDTH);

	localparam int PIX_W       = 16;
	localparam int COEF_W      = 16;
	localparam int KROW_W      = 3 * COEF_W;
	localparam int PROD_W      = PIX_W + 1 + COEF_W;
	localparam int SUM3_W      = PROD_W + 2;
	localparam int VALUE_W     = 36;
	localparam int ROW_W       = 16;
	localparam int OUT_COL_W   = 10;
	localparam int WIDTH_REG_W = 11;
	localparam int EW          = (WIDTH_REG_W > LB_AW + 1) ? WIDTH_REG_W : LB_AW + 1;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;

	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam int OUT_TDATA_W = ((VALUE_W + ROW_W + OUT_COL_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_TOP = 3'd0,
		REG_KERNEL_MID = 3'd1,
		REG_KERNEL_BOT = 3'd2,
		REG_IMG_WIDTH  = 3'd3,
		REG_IMG_HEIGHT = 3'd4
	} reg_idx_t;

	// Window pixels, element 3*i+j is row i, column j (column 2 newest).
	typedef struct packed {
		logic [8:0][PIX_W-1:0]  pix;
		logic [ROW_W-1:0]       row;
		logic [OUT_COL_W-1:0]   col;
		logic                   last;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} push_t;

	typedef struct packed {
		logic              not_empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

// File: sv/c2d_ram.sv
// ---------------------------------------------------------------------------
// c2d_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/c2d_front.sv
// ---------------------------------------------------------------------------
// c2d_front
// Pixel intake: position counters, line buffers, window and classification.
// ---------------------------------------------------------------------------
module c2d_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [c2d_pkg::PIX_W-1:0]     in_pixel,
	input  logic [c2d_pkg::WIDTH_REG_W-1:0] image_width,
	input  logic [c2d_pkg::ROW_W-1:0]     image_height,
	input  c2d_pkg::qstat_t               qstat,
	output c2d_pkg::push_t                push
);

	localparam int EW = c2d_pkg::EW;
	localparam int AW = c2d_pkg::LB_AW;
	localparam int RW = c2d_pkg::ROW_W;

	logic [EW-1:0]            w_eff, w_raw, c_inc;
	logic [RW-1:0]            h_eff, r0;
	logic [RW:0]              r_n, r1;
	logic [AW-1:0]            c_n, col_next, col_q;
	logic [RW-1:0]            row_next, row_q;
	logic                     accept, emit;

	logic                     valid_s1, emit_s1, last_s1;
	logic [c2d_pkg::PIX_W-1:0] px_s1;
	logic [AW-1:0]            addr_s1;
	logic [RW-1:0]            row_s1;
	logic [c2d_pkg::OUT_COL_W-1:0] col_s1;

	logic [c2d_pkg::PIX_W-1:0] prev_rd, prev2_rd;
	logic [8:0][c2d_pkg::PIX_W-1:0] window_q, window_new;

	// Room check counts the item still in stage 1 as already queued.
	assign in_ready = (c2d_pkg::QCNT_W'(qstat.count) + c2d_pkg::QCNT_W'(valid_s1))
		< c2d_pkg::QCNT_W'(c2d_pkg::QDEPTH);
	assign accept = in_valid && in_ready;

	always_comb begin
		w_raw = EW'(image_width);
		if (w_raw < EW'(3)) begin
			w_eff = EW'(3);
		end else if (w_raw > EW'(c2d_pkg::MAX_WIDTH)) begin
			w_eff = EW'(c2d_pkg::MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		h_eff = (image_height < RW'(3)) ? RW'(3) : image_height;

		// Normalise the stored position against the current size.
		c_n = col_q;
		r_n = {1'b0, row_q};
		if (EW'(col_q) >= w_eff) begin
			c_n = '0;
			r_n = r_n + (RW+1)'(1);
		end
		if (r_n >= {1'b0, h_eff}) begin
			r_n = '0;
		end
		r0 = r_n[RW-1:0];

		c_inc = EW'(c_n) + EW'(1);
		r1    = {1'b0, r0} + (RW+1)'(1);
		if (c_inc >= w_eff) begin
			col_next = '0;
			row_next = (r1 >= {1'b0, h_eff}) ? '0 : r1[RW-1:0];
		end else begin
			col_next = c_inc[AW-1:0];
			row_next = r0;
		end

		emit = (r0 >= RW'(2)) && (c_n >= AW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				col_q <= col_next;
				row_q <= row_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= in_pixel;
			addr_s1 <= c_n;
			emit_s1 <= emit;
			row_s1  <= r0 - RW'(2);
			col_s1  <= c2d_pkg::OUT_COL_W'(c_n - AW'(2));
			last_s1 <= (r0 == h_eff - RW'(1)) && (EW'(c_n) == w_eff - EW'(1));
		end
	end

	// Previous row and the row before it, read on intake, written back in stage 1.
	c2d_ram #(.WIDTH(c2d_pkg::PIX_W), .DEPTH(c2d_pkg::MAX_WIDTH)) u_line_prev (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (c_n),
		.rdata (prev_rd)
	);

	c2d_ram #(.WIDTH(c2d_pkg::PIX_W), .DEPTH(c2d_pkg::MAX_WIDTH)) u_line_prev2 (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (prev_rd),
		.re    (accept),
		.raddr (c_n),
		.rdata (prev2_rd)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			window_new[3*i]   = window_q[3*i+1];
			window_new[3*i+1] = window_q[3*i+2];
		end
		window_new[2] = prev2_rd;
		window_new[5] = prev_rd;
		window_new[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (valid_s1) begin
			window_q <= window_new;
		end
	end

	assign push.valid     = valid_s1 && emit_s1;
	assign push.item.pix  = window_new;
	assign push.item.row  = row_s1;
	assign push.item.col  = col_s1;
	assign push.item.last = last_s1;

endmodule

// File: sv/c2d_queue.sv
// ---------------------------------------------------------------------------
// c2d_queue
// Short register FIFO of complete windows between intake and arithmetic.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module c2d_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  c2d_pkg::push_t   push,
	input  logic             pop,
	output c2d_pkg::item_t   head,
	output c2d_pkg::qstat_t  qstat
);

	c2d_pkg::item_t               store_q [c2d_pkg::QDEPTH];
	logic [c2d_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [c2d_pkg::QCNT_W-1:0]   count_q;
	logic                         do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + c2d_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + c2d_pkg::QPTR_W'(1);
			end
			count_q <= count_q + c2d_pkg::QCNT_W'(push.valid) - c2d_pkg::QCNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			store_q[wr_ptr_q] <= push.item;
		end
	end

	assign head            = store_q[rd_ptr_q];
	assign qstat.count     = count_q;
	assign qstat.not_empty = (count_q != '0);

	`C2D_ASSERT(a_no_overflow, push.valid, count_q < c2d_pkg::QCNT_W'(c2d_pkg::QDEPTH), "queue push while full")
	`C2D_ASSERT(a_no_underflow, pop, count_q != '0, "queue pop while empty")
	`C2D_ASSERT_NEXT(a_count_up, push.valid && !do_pop, count_q == $past(count_q) + c2d_pkg::QCNT_W'(1), "queue count lost a push")

endmodule

// File: sv/c2d_back.sv
// ---------------------------------------------------------------------------
// c2d_back
// Nine-tap multiply and adder tree with stall-able stages and output register.
// ---------------------------------------------------------------------------
module c2d_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [2:0][c2d_pkg::KROW_W-1:0]    kernel,
	input  c2d_pkg::qstat_t                    qstat,
	input  c2d_pkg::item_t                     head,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [c2d_pkg::VALUE_W-1:0] out_value,
	output logic [c2d_pkg::ROW_W-1:0]          out_row,
	output logic [c2d_pkg::OUT_COL_W-1:0]      out_col,
	output logic                               out_last
);

	localparam int PW = c2d_pkg::PROD_W;
	localparam int SW = c2d_pkg::SUM3_W;
	localparam int VW = c2d_pkg::VALUE_W;

	logic                  en_s1, en_s2, en_s3;
	logic                  valid_s1, valid_s2, valid_s3;
	logic signed [PW-1:0]  prod [9];
	logic signed [PW-1:0]  prod_s1 [9];
	logic signed [SW-1:0]  rsum_s2 [3];
	logic signed [VW-1:0]  value_s3;
	logic [c2d_pkg::ROW_W-1:0]     row_s1, row_s2, row_s3;
	logic [c2d_pkg::OUT_COL_W-1:0] col_s1, col_s2, col_s3;
	logic                  last_s1, last_s2, last_s3;
	logic signed [c2d_pkg::PIX_W:0]     px_ext [9];
	logic signed [c2d_pkg::COEF_W-1:0]  coef [9];

	// Advance a stage when it is empty or its successor moves.
	assign en_s3 = !valid_s3 || out_ready;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign pop   = qstat.not_empty && en_s1;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			px_ext[k] = $signed({1'b0, head.pix[k]});
			coef[k]   = $signed(kernel[k/3][(k%3)*c2d_pkg::COEF_W +: c2d_pkg::COEF_W]);
			prod[k]   = px_ext[k] * coef[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= pop;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= prod;
			row_s1  <= head.row;
			col_s1  <= head.col;
			last_s1 <= head.last;
		end
		if (en_s2) begin
			for (int i = 0; i < 3; i++) begin
				rsum_s2[i] <= SW'(prod_s1[3*i]) + SW'(prod_s1[3*i+1]) + SW'(prod_s1[3*i+2]);
			end
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
		end
		if (en_s3) begin
			value_s3 <= VW'(rsum_s2[0]) + VW'(rsum_s2[1]) + VW'(rsum_s2[2]);
			row_s3   <= row_s2;
			col_s3   <= col_s2;
			last_s3  <= last_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_value = value_s3;
	assign out_row   = row_s3;
	assign out_col   = col_s3;
	assign out_last  = last_s3;

endmodule

// File: sv/conv2d_3x3_valid_top.sv
// ---------------------------------------------------------------------------
// conv2d_3x3_valid_top
// 3x3 valid-region correlation over a raster pixel stream.
// ---------------------------------------------------------------------------
// Pixels arrive in raster order, one per transaction, and the block sustains
// one pixel per clock when the output is not stalled: intake, the line-buffer
// read and write-back, and each arithmetic stage all move one item a cycle.
// For every pixel at image row and column of at least 2 one result follows,
// the exact signed 36-bit sum of the nine window pixels times the matching
// kernel coefficients (no kernel flip), tagged with its valid-region row and
// column and tlast on the bottom-right window. The pixel and its line-buffer
// reads are registered at intake; the window passes the queue, then the
// multiply, row-sum and final-sum registers. Two line buffers of MAX_WIDTH
// pixels each sit in single-port-read RAMs and are not cleared after reset;
// every entry that feeds a result has been written first as long as the
// image size is left alone while an image is in progress. A four-entry queue
// of complete windows separates the intake from the arithmetic, so a stalled
// output does not stop the intake until that queue fills. Write the
// configuration registers only while the block is idle.
// ---------------------------------------------------------------------------
module conv2d_3x3_valid_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [c2d_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [c2d_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// pixel stream in
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [c2d_pkg::PIX_W-1:0]           s_tdata,   // [15:0] pixel
	// result stream out
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [c2d_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [35:0] value, [51:36] out_row,
	                                                       // [61:52] out_col, rest zero
	output logic                                m_tlast    // last result of the image
);

	logic [2:0][c2d_pkg::KROW_W-1:0]      kernel_q;
	logic [c2d_pkg::WIDTH_REG_W-1:0]      image_width_q;
	logic [c2d_pkg::ROW_W-1:0]            image_height_q;

	c2d_pkg::qstat_t                      qstat;
	c2d_pkg::push_t                       push;
	c2d_pkg::item_t                       head;
	logic                                 pop;

	logic signed [c2d_pkg::VALUE_W-1:0]   out_value;
	logic [c2d_pkg::ROW_W-1:0]            out_row;
	logic [c2d_pkg::OUT_COL_W-1:0]        out_col;

	// Register file; writes to unlisted indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q       <= '0;
			image_width_q  <= c2d_pkg::WIDTH_REG_W'(6);
			image_height_q <= c2d_pkg::ROW_W'(6);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				c2d_pkg::REG_KERNEL_TOP: begin
					kernel_q[0] <= cfg_wdata[c2d_pkg::KROW_W-1:0];
				end
				c2d_pkg::REG_KERNEL_MID: begin
					kernel_q[1] <= cfg_wdata[c2d_pkg::KROW_W-1:0];
				end
				c2d_pkg::REG_KERNEL_BOT: begin
					kernel_q[2] <= cfg_wdata[c2d_pkg::KROW_W-1:0];
				end
				c2d_pkg::REG_IMG_WIDTH: begin
					image_width_q <= cfg_wdata[c2d_pkg::WIDTH_REG_W-1:0];
				end
				c2d_pkg::REG_IMG_HEIGHT: begin
					image_height_q <= cfg_wdata[c2d_pkg::ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Intake: track position, shift the window, queue only full windows.
	c2d_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_pixel     (s_tdata),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.qstat        (qstat),
		.push         (push)
	);

	c2d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// Arithmetic: multiply, sum per kernel row, final sum held for the sink.
	c2d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.kernel    (kernel_q),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (out_value),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (m_tlast)
	);

	assign m_tdata = c2d_pkg::OUT_TDATA_W'({out_col, out_row, out_value});

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 valid-region correlation block.
// ---------------------------------------------------------------------------
// Pixels are queued by a sequencer, presented by a clocked stream driver and
// folded into a bit-exact shadow of the line buffers, window and raster
// position on every accepted transaction. Each window sum the shadow produces
// waits in a queue until the result monitor pops it and compares value, row,
// column and the last flag. The run starts with short hand-written images
// (coefficient and pixel extremes, undersized size registers, writes to
// unmapped indexes), then random phases with random kernels and sizes, some
// ending in the middle of an image so that a later size change lands
// mid-image. A width picked for such a change is held to the columns that
// both line buffers already hold, so no unwritten entry is ever read.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
	localparam int DRAIN_LIMIT = 20000;   // bound on any single drain wait
	localparam int SETTLE      = 20;      // pipeline depth plus margin
	localparam int TOTAL_ITEMS = 1250;

	localparam logic [c2d_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [c2d_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [c2d_pkg::COEF_W-1:0] COEF_MIN = 16'h8000;
	localparam logic [c2d_pkg::COEF_W-1:0] COEF_MAX = 16'h7FFF;
	localparam logic [c2d_pkg::PIX_W-1:0]  PIX_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [c2d_pkg::VALUE_W-1:0]   value;
		logic [c2d_pkg::ROW_W-1:0]     row;
		logic [c2d_pkg::OUT_COL_W-1:0] col;
		logic                          is_last;
	} window_sum_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	logic [c2d_pkg::CFG_IDX_W-1:0]      cfg_addr = '0;
	logic [c2d_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
	logic                               s_tvalid = 1'b0;
	logic                               s_tready;
	logic [c2d_pkg::PIX_W-1:0]          s_tdata = '0;
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	logic [c2d_pkg::OUT_TDATA_W-1:0]    m_tdata;
	logic                               m_tlast;

	// Shadow of the block: register file, line buffers, window, raster position.
	logic [c2d_pkg::KROW_W-1:0]      kernel_rows [0:2] = '{default: '0};
	logic [c2d_pkg::WIDTH_REG_W-1:0] width_reg = 11'd6;
	logic [c2d_pkg::ROW_W-1:0]       height_reg = 16'd6;
	logic [c2d_pkg::PIX_W-1:0]       line_buf [0:2*c2d_pkg::MAX_WIDTH-1] = '{default: '0};
	logic                            line_wr [0:2*c2d_pkg::MAX_WIDTH-1] = '{default: 1'b0};
	logic [c2d_pkg::PIX_W-1:0]       win [0:2][0:2] = '{default: '{default: '0}};
	logic [c2d_pkg::ROW_W-1:0]       row_pos = '0;
	logic [c2d_pkg::WIDTH_REG_W-1:0] col_pos = '0;

	logic [c2d_pkg::PIX_W-1:0] pixel_queue [$];
	window_sum_t               window_sums [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int cycle_count = 0;

	conv2d_3x3_valid_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic int unsigned eff_width();
		int unsigned w;
		w = width_reg;
		if (w < 3) w = 3;
		if (w > c2d_pkg::MAX_WIDTH) w = c2d_pkg::MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned h;
		h = height_reg;
		if (h < 3) h = 3;
		return h;
	endfunction

	// Leading columns for which both line buffers hold a written pixel.
	function automatic int unsigned filled_width();
		int unsigned n;
		n = 0;
		while (n < c2d_pkg::MAX_WIDTH && line_wr[n] && line_wr[c2d_pkg::MAX_WIDTH + n])
			n++;
		return n;
	endfunction

	// Advance the shadow by one pixel; queue the window sum once the window
	// covers a full 3x3 patch of the image.
	function automatic void correlate_pixel(input logic [c2d_pkg::PIX_W-1:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		longint acc;
		logic signed [c2d_pkg::COEF_W-1:0] k;
		window_sum_t s;
		w = eff_width();
		h = eff_height();
		// A size shrunk under the current position pushes the pixel on.
		if (col_pos >= w) begin
			col_pos = '0;
			row_pos = row_pos + 1'b1;
		end
		if (row_pos >= h)
			row_pos = '0;
		c = col_pos;
		r = row_pos;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = line_buf[c2d_pkg::MAX_WIDTH + c];
		win[1][2] = line_buf[c];
		win[2][2] = px;
		line_buf[c2d_pkg::MAX_WIDTH + c] = line_buf[c];
		line_buf[c] = px;
		line_wr[c2d_pkg::MAX_WIDTH + c] = line_wr[c];
		line_wr[c] = 1'b1;
		col_pos = c2d_pkg::WIDTH_REG_W'(c + 1);
		if (col_pos >= w) begin
			col_pos = '0;
			row_pos = c2d_pkg::ROW_W'(r + 1);
			if (row_pos >= h)
				row_pos = '0;
		end
		if (r >= 2 && c >= 2) begin
			acc = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					k = kernel_rows[i][c2d_pkg::COEF_W*j +: c2d_pkg::COEF_W];
					acc += longint'(win[i][j]) * longint'(k);
				end
			s.value   = acc[c2d_pkg::VALUE_W-1:0];
			s.row     = c2d_pkg::ROW_W'(r - 2);
			s.col     = c2d_pkg::OUT_COL_W'(c - 2);
			s.is_last = (r == h - 1) && (c == w - 1);
			window_sums.push_back(s);
		end
	endfunction

	// Stream driver: hold the pixel while stalled, idle at random between
	// transactions, fold each accepted pixel into the shadow.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				correlate_pixel(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pixel_queue.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare every accepted result against the oldest sum.
	always @(posedge clk) begin
		window_sum_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (window_sums.size() == 0) begin
					$error("result with nothing pending: value %0d row %0d col %0d",
						$signed(m_tdata[35:0]), m_tdata[51:36], m_tdata[61:52]);
					fail_count++;
				end else begin
					want = window_sums.pop_front();
					if (m_tdata[35:0] !== want.value) begin
						$error("value: expected %0d, got %0d",
							$signed(want.value), $signed(m_tdata[35:0]));
						fail_count++;
					end
					if (m_tdata[51:36] !== want.row) begin
						$error("out_row: expected %0d, got %0d", want.row, m_tdata[51:36]);
						fail_count++;
					end
					if (m_tdata[61:52] !== want.col) begin
						$error("out_col: expected %0d, got %0d", want.col, m_tdata[61:52]);
						fail_count++;
					end
					if (m_tlast !== want.is_last) begin
						$error("last: expected %0b, got %0b", want.is_last, m_tlast);
						fail_count++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic logic [c2d_pkg::CFG_DATA_W-1:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [c2d_pkg::COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return COEF_MIN;
			1: return COEF_MAX;
			2: return 16'($urandom_range(0, 8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [c2d_pkg::PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return PIX_MAX;
			default: return 16'($urandom);
		endcase
	endfunction

	// One register write; the block takes it at the edge where cfg_we is high.
	task automatic cfg_write(input logic [c2d_pkg::CFG_IDX_W-1:0] idx,
		input logic [c2d_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			c2d_pkg::REG_KERNEL_TOP: kernel_rows[0] = data;
			c2d_pkg::REG_KERNEL_MID: kernel_rows[1] = data;
			c2d_pkg::REG_KERNEL_BOT: kernel_rows[2] = data;
			c2d_pkg::REG_IMG_WIDTH:  width_reg = data[c2d_pkg::WIDTH_REG_W-1:0];
			c2d_pkg::REG_IMG_HEIGHT: height_reg = data[c2d_pkg::ROW_W-1:0];
			default: ;
		endcase
	endtask

	// Load all five registers; junk the unused upper bits of the size writes.
	task automatic set_image(input logic [c2d_pkg::KROW_W-1:0] top,
		input logic [c2d_pkg::KROW_W-1:0] mid, input logic [c2d_pkg::KROW_W-1:0] bot,
		input logic [c2d_pkg::WIDTH_REG_W-1:0] w, input logic [c2d_pkg::ROW_W-1:0] h);
		logic [c2d_pkg::CFG_DATA_W-1:0] wd;
		logic [c2d_pkg::CFG_DATA_W-1:0] hd;
		wd = rand48();
		hd = rand48();
		wd[c2d_pkg::WIDTH_REG_W-1:0] = w;
		hd[c2d_pkg::ROW_W-1:0] = h;
		cfg_write(c2d_pkg::REG_KERNEL_TOP, top);
		cfg_write(c2d_pkg::REG_KERNEL_MID, mid);
		cfg_write(c2d_pkg::REG_KERNEL_BOT, bot);
		cfg_write(c2d_pkg::REG_IMG_WIDTH, wd);
		cfg_write(c2d_pkg::REG_IMG_HEIGHT, hd);
	endtask

	// Wait for every queued pixel and every pending sum, then let the
	// pipeline run dry: the last pixels may still be in flight with no result.
	task automatic drain();
		int guard;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while ((pixel_queue.size() != 0 || s_tvalid || window_sums.size() != 0)
			&& guard < DRAIN_LIMIT);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			pixel_queue.push_back(rand_pixel());
	endtask

	initial begin
		int sent;
		int n;
		int area;
		int unsigned ew;
		int unsigned fw;
		logic [c2d_pkg::WIDTH_REG_W-1:0] w;
		logic [c2d_pkg::ROW_W-1:0] h;
		logic [c2d_pkg::PIX_W-1:0] mixed [0:8];

		sent = 0;
		send_idle_pct = 27;
		recv_idle_pct = 52;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Most negative sum: all pixels full scale, all coefficients at minimum.
		// Width and height below three act as three.
		set_image({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}}, 11'd1, 16'd2);
		cfg_write(REG_SPARE_LO, '1);
		cfg_write(REG_SPARE_HI, '1);
		repeat (9) pixel_queue.push_back(PIX_MAX);
		sent += 9;
		drain();

		// Mixed signs and bit patterns, sizes written as zero.
		mixed = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h8000,
			16'h7FFF, 16'h0001, 16'hFFFE, 16'hFFFF};
		set_image({COEF_MAX, 16'h0001, COEF_MIN}, {16'hFFFF, 16'h0000, COEF_MAX},
			{16'h0002, 16'hFFFE, COEF_MAX}, 11'd0, 16'd0);
		for (int i = 0; i < 9; i++)
			pixel_queue.push_back(mixed[i]);
		sent += 9;
		drain();

		// Most positive sum.
		set_image({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}}, 11'd3, 16'd3);
		repeat (9) pixel_queue.push_back(PIX_MAX);
		sent += 9;
		drain();

		// Random phases; some stop mid-image so the next phase resizes it.
		while (sent < TOTAL_ITEMS) begin
			if (sent < TOTAL_ITEMS / 3) begin
				send_idle_pct = 27;
				recv_idle_pct = 52;
			end else if (sent < 2 * TOTAL_ITEMS / 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case ($urandom_range(0, 19))
				0, 1:   w = 11'($urandom_range(0, 2));
				2, 3, 4: w = 11'($urandom_range(11, 48));
				5:      w = 11'(c2d_pkg::MAX_WIDTH);
				6:      w = 11'($urandom_range(c2d_pkg::MAX_WIDTH + 1, 2047));
				default: w = 11'($urandom_range(3, 10));
			endcase
			case ($urandom_range(0, 9))
				0:    h = 16'($urandom_range(0, 2));
				1:    h = 16'($urandom_range(9, 40));
				2:    h = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom);
				default: h = 16'($urandom_range(3, 8));
			endcase
			// Mid-image, keep the new width within columns both line buffers hold.
			if (row_pos != '0 || col_pos != '0) begin
				ew = w;
				if (ew < 3) ew = 3;
				if (ew > c2d_pkg::MAX_WIDTH) ew = c2d_pkg::MAX_WIDTH;
				fw = filled_width();
				if (ew > fw)
					w = c2d_pkg::WIDTH_REG_W'(fw);
			end
			set_image({rand_coef(), rand_coef(), rand_coef()},
				{rand_coef(), rand_coef(), rand_coef()},
				{rand_coef(), rand_coef(), rand_coef()}, w, h);
			area = eff_width() * eff_height();
			n = ($urandom_range(0, 1) != 0) ? area : $urandom_range(1, 2 * area);
			if (n > 300) n = 300;
			queue_random(n);
			sent += n;
			drain();
		end

		drain();
		if (window_sums.size() != 0) begin
			$error("%0d window sums never arrived", window_sums.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
